[design/lifo_pkg.sv]
// Shared types and constants for the bounded LIFO stack.
package lifo_pkg;

   // Fixed widths of the request and response words
   localparam int KIND_BITS   = 2;
   localparam int POS_BITS    = 3;
   localparam int VALUE_BITS  = 32;
   localparam int DATA_BITS   = 32;
   localparam int STATUS_BITS = 2;
   localparam int FILL_BITS   = 4;

   // Operation codes carried in the kind field
   typedef enum logic [KIND_BITS-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_CHANGE = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // Control broadcast from the stack controller to every cell
   typedef struct packed {
      logic push;    // write the incoming word at the current fill count
      logic pop;     // clear the entry just below the fill count
      logic change;  // overwrite the entry at the requested position
      logic rd_top;  // drive the read chain from the top entry, not the position
   } cell_ctrl_type;

endpackage

[design/lifo_if.sv]
// Request and response channel interfaces for the bounded LIFO stack.
interface lifo_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [lifo_pkg::KIND_BITS-1:0]         kind;
   logic [lifo_pkg::POS_BITS-1:0]          position;
   logic signed [lifo_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface lifo_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [lifo_pkg::DATA_BITS-1:0] data;
   logic [lifo_pkg::STATUS_BITS-1:0]      status;
   logic [lifo_pkg::FILL_BITS-1:0]        fill_count;
   logic                                  is_empty;
   logic                                  is_full;

   modport source (output valid, data, status, fill_count, is_empty, is_full, input ready);
   modport sink   (input valid, data, status, fill_count, is_empty, is_full, output ready);
endinterface

[design/lifo_cell.sv]
// One stack entry: holds a word, decodes its own write and clear, joins the read chain.
module lifo_cell #(
   parameter int WORD_BITS = 32,
   parameter int CNT_BITS  = 4,
   parameter int INDEX     = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lifo_pkg::cell_ctrl_type       ctrl,
   input  logic [CNT_BITS-1:0]           count,
   input  logic [lifo_pkg::POS_BITS-1:0] position,
   input  logic [WORD_BITS-1:0]          wr_word,
   input  logic [WORD_BITS-1:0]          rd_chain_in,
   output logic [WORD_BITS-1:0]          rd_chain_out
);

   localparam logic [CNT_BITS-1:0] MY_IDX    = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] MY_IDX_P1 = CNT_BITS'(INDEX + 1);

   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 pos_hit;
   logic                 top_hit;
   logic                 rd_sel;

   // Decode which request targets this entry
   always_comb begin
      pos_hit = (int'(position) == INDEX);
      top_hit = (count == MY_IDX_P1);
      rd_sel  = ctrl.rd_top ? top_hit : pos_hit;
   end

   // Pass the neighbor's word along unless this entry is the one being read
   assign rd_chain_out = rd_sel ? word_ff : rd_chain_in;

   // Load on push or change, clear on pop, otherwise hold
   always_comb begin
      word_in = word_ff;
      if (ctrl.push && (count == MY_IDX)) begin
         word_in = wr_word;
      end else if (ctrl.pop && top_hit) begin
         word_in = '0;
      end else if (ctrl.change && pos_hit) begin
         word_in = wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

endmodule

[design/bounded_lifo_stack.sv]
// Bounded LIFO stack: controller, fill count, response register and the row of entry cells.
// A response word is registered when its request word is accepted and appears in the following cycle.
// Throughput: one request word per cycle; the registered response stage sets the pace,
// and a new request is taken whenever that stage is empty or being drained.
// Reads go through the cell read chain, DEPTH cells deep, within the accept cycle.
// Reset (synchronous, active high) empties the stack and clears every entry to zero.
module bounded_lifo_stack #(
   parameter int DEPTH     = 8,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   lifo_req_if.sink    req_bus,
   lifo_rsp_if.source  rsp_bus
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int EXT_BITS = (WORD_BITS > lifo_pkg::DATA_BITS) ? WORD_BITS : lifo_pkg::DATA_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   logic [CNT_BITS-1:0]                   count_ff, count_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [lifo_pkg::DATA_BITS-1:0] data_ff, data_in;
   lifo_pkg::status_type                  status_ff, status_in;
   logic [lifo_pkg::FILL_BITS-1:0]        fill_ff, fill_in;
   logic                                  empty_ff, empty_in;
   logic                                  full_ff, full_in;

   logic                                  accept;
   lifo_pkg::op_type                      op;
   lifo_pkg::cell_ctrl_type               ctrl;
   logic                                  pos_out;
   logic                                  is_zero;
   logic                                  at_full;
   logic                                  use_rd;
   logic [CNT_BITS-1:0]                   new_count;
   logic [WORD_BITS-1:0]                  wr_word;
   logic [WORD_BITS-1:0]                  rd_chain [DEPTH:0];
   logic signed [EXT_BITS-1:0]            rd_ext;

   // Take a request word when the response stage is empty or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Store the low WORD_BITS of the value, zero-filled above 32 bits
   assign wr_word = WORD_BITS'($unsigned(req_bus.value));

   // Sign-extend the word read from the chain
   assign rd_ext = EXT_BITS'(signed'(rd_chain[0]));

   // Decode the operation, check it and drive the cell controls
   always_comb begin
      op        = lifo_pkg::op_type'(req_bus.kind);
      pos_out   = (int'(req_bus.position) >= DEPTH);
      is_zero   = (count_ff == '0);
      at_full   = (count_ff == FULL_COUNT);
      status_in = lifo_pkg::ST_OK;
      ctrl      = '0;
      use_rd    = 1'b0;
      new_count = count_ff;
      case (op)
         lifo_pkg::OP_PUSH: begin
            if (at_full) begin
               status_in = lifo_pkg::ST_OVERFLOW;
            end else begin
               ctrl.push = accept;
               new_count = count_ff + CNT_BITS'(1);
            end
         end
         lifo_pkg::OP_POP: begin
            ctrl.rd_top = 1'b1;
            if (is_zero) begin
               status_in = lifo_pkg::ST_UNDERFLOW;
            end else begin
               ctrl.pop  = accept;
               use_rd    = 1'b1;
               new_count = count_ff - CNT_BITS'(1);
            end
         end
         lifo_pkg::OP_PEEK: begin
            if (is_zero) begin
               status_in = lifo_pkg::ST_UNDERFLOW;
            end else if (pos_out) begin
               status_in = lifo_pkg::ST_RANGE;
            end else begin
               use_rd = 1'b1;
            end
         end
         lifo_pkg::OP_CHANGE: begin
            if (pos_out) begin
               status_in = lifo_pkg::ST_RANGE;
            end else begin
               ctrl.change = accept;
            end
         end
         default: begin
            status_in = lifo_pkg::ST_OK;
         end
      endcase

      count_in = accept ? new_count : count_ff;
      data_in  = use_rd ? rd_ext[lifo_pkg::DATA_BITS-1:0] : '0;
      fill_in  = lifo_pkg::FILL_BITS'(new_count);
      empty_in = (new_count == '0);
      full_in  = (new_count == FULL_COUNT);

      // Raise valid on accept, drop it once the word is taken
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         fill_ff   <= fill_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.data       = data_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.fill_count = fill_ff;
   assign rsp_bus.is_empty   = empty_ff;
   assign rsp_bus.is_full    = full_ff;

   // Row of entry cells, bottom entry at index zero; the read chain ends in zero
   assign rd_chain[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      lifo_cell #(
         .WORD_BITS (WORD_BITS),
         .CNT_BITS  (CNT_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .count        (count_ff),
         .position     (req_bus.position),
         .wr_word      (wr_word),
         .rd_chain_in  (rd_chain[i+1]),
         .rd_chain_out (rd_chain[i])
      );
   end

endmodule
